/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rrps_pkg.sv */
package rrps_pkg;

  localparam int MAX_BEACONS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  localparam int ID_W    = 4;
  localparam int ID_MAX  = 15;
  localparam int NUM_IDS = ID_MAX + 1;
  localparam int EV_W    = 3;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RX   = 2'd1,
    CMD_DRV  = 2'd2,
    CMD_HB   = 2'd3
  } cmd_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_POLL    = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_NODE_TO = 3'd3,
    EV_DRV_TO  = 3'd4,
    EV_BAD     = 3'd5,
    EV_SKIP    = 3'd6
  } ev_t;

  typedef enum logic [2:0] {
    REG_ORDER_TABLE = 3'd0,
    REG_ORDER_COUNT = 3'd1,
    REG_POLL_PERIOD = 3'd2,
    REG_RESP_TO     = 3'd3,
    REG_DIRECT_TO   = 3'd4,
    REG_EN_DIRECT   = 3'd5,
    REG_EN_ACOUSTIC = 3'd6,
    REG_RTO_CODE    = 3'd7
  } reg_idx_t;

  localparam logic [31:0] PERIOD_RST = 32'd100;
  localparam logic [31:0] RESP_TO_RST = 32'd100;
  localparam logic [31:0] DIRECT_TO_RST = 32'd100;

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic [ID_W-1:0] beacon;
    logic            last;
  } res_t;

endpackage

/* rtl/rrps_in_if.sv */
interface rrps_in_if;
  import rrps_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [ID_W-1:0] beacon;
  logic            for_us;
  logic            decode_ok;
  logic [7:0]      status_code;

  modport source (output valid, cmd, beacon, for_us, decode_ok, status_code,
                  input ready);
  modport sink   (input valid, cmd, beacon, for_us, decode_ok, status_code,
                  output ready);
endinterface

/* rtl/rrps_out_if.sv */
interface rrps_out_if;
  import rrps_pkg::*;

  logic            valid;
  logic            ready;
  logic [EV_W-1:0] event_res;
  logic [ID_W-1:0] event_beacon;
  logic            last;

  modport source (output valid, event_res, event_beacon, last, input ready);
  modport sink   (input valid, event_res, event_beacon, last, output ready);
endinterface

/* rtl/round_robin_poll_scheduler.sv */
// Round-robin status poller. Each accepted event word (tick, modem reception,
// driver update, heartbeat) is evaluated in the cycle it is taken and the
// state registers update at that edge, so an event can be accepted every
// cycle while in_ch.ready is high. An event produces zero, one or two result
// words, written into a four-entry output queue; in_ch.ready is high while
// the queue has room for two words. The result side drains one word per
// cycle while out_ch.ready is high, so the sustained rate is one event per
// cycle as long as the average stays at or below one result per event and
// the result side is not held. Configuration is over an APB-style port with
// 64-bit data, register i at byte address 8*i.
`include "assert_macros.svh"

module round_robin_poll_scheduler #(
  parameter int MAX_BEACONS = rrps_pkg::MAX_BEACONS_DEF,
  parameter int TIME_BITS   = rrps_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rrps_in_if.sink                     in_ch,
  rrps_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrps_pkg::CFG_AW-1:0] paddr,
  input  logic [rrps_pkg::CFG_DW-1:0] pwdata,
  output logic [rrps_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import rrps_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int CW = (TW > 32) ? TW : 32;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};
  localparam logic [4:0] CNT_MAX = 5'(MAX_BEACONS);
  localparam int QD = 4;
  localparam int QP = $clog2(QD);

  // configuration
  logic [63:0] order_table_r;
  logic [4:0]  order_count_r;
  logic [31:0] period_r, resp_to_r, direct_to_r;
  logic        en_direct_r, en_acoustic_r;
  logic [7:0]  rto_code_r;

  // poller state
  logic [TW-1:0]   now_r, req_tick_r, next_poll_r;
  logic            awaiting_r;
  logic [ID_W-1:0] pending_r, oidx_r;
  logic [NUM_IDS-1:0] heard_r;
  logic [TW-1:0]   heard_tick_r [NUM_IDS];

  // output queue
  res_t          q_r [QD];
  logic [QP-1:0] wr_ptr_r, rd_ptr_r;
  logic [QP:0]   q_cnt_r, q_cnt_nxt;

  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_comb begin
    case (cfg_idx)
      REG_ORDER_TABLE: prdata = order_table_r;
      REG_ORDER_COUNT: prdata = 64'(order_count_r);
      REG_POLL_PERIOD: prdata = 64'(period_r);
      REG_RESP_TO:     prdata = 64'(resp_to_r);
      REG_DIRECT_TO:   prdata = 64'(direct_to_r);
      REG_EN_DIRECT:   prdata = 64'(en_direct_r);
      REG_EN_ACOUSTIC: prdata = 64'(en_acoustic_r);
      REG_RTO_CODE:    prdata = 64'(rto_code_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_table_r <= '0;
      order_count_r <= '0;
      period_r      <= PERIOD_RST;
      resp_to_r     <= RESP_TO_RST;
      direct_to_r   <= DIRECT_TO_RST;
      en_direct_r   <= 1'b0;
      en_acoustic_r <= 1'b1;
      rto_code_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORDER_TABLE: order_table_r <= pwdata;
        REG_ORDER_COUNT: order_count_r <= pwdata[4:0];
        REG_POLL_PERIOD: period_r      <= pwdata[31:0];
        REG_RESP_TO:     resp_to_r     <= pwdata[31:0];
        REG_DIRECT_TO:   direct_to_r   <= pwdata[31:0];
        REG_EN_DIRECT:   en_direct_r   <= pwdata[0];
        REG_EN_ACOUSTIC: en_acoustic_r <= pwdata[0];
        REG_RTO_CODE:    rto_code_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // event evaluation
  logic          accept;
  logic          is_tick;
  logic [TW-1:0] now_upd, age_req, room, sched, age_hb;
  logic          node_to, rx_hit, drv_hit, end_req;
  ev_t           end_ev;
  logic [4:0]    cnt;
  logic          poll_open, poll_go, link_up, skip, send;
  logic [ID_W-1:0] idx, idx_nxt, pb;
  logic          pres;
  res_t          r0, r1;
  logic [1:0]    n_res;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_tick = (in_ch.cmd == CMD_TICK);

  always_comb begin
    now_upd = (is_tick && now_r != TMAX) ? now_r + TW'(1) : now_r;
    age_req = now_upd - req_tick_r;
    node_to = is_tick && awaiting_r && (CW'(age_req) > CW'(resp_to_r));
    rx_hit  = (in_ch.cmd == CMD_RX) && awaiting_r && in_ch.for_us &&
              (in_ch.beacon == pending_r);
    drv_hit = (in_ch.cmd == CMD_DRV) && awaiting_r && (in_ch.beacon == pending_r) &&
              (in_ch.status_code == rto_code_r);
    end_req = node_to || rx_hit || drv_hit;
    if (node_to)
      end_ev = EV_NODE_TO;
    else if (drv_hit)
      end_ev = EV_DRV_TO;
    else if (in_ch.decode_ok)
      end_ev = EV_ACCEPT;
    else
      end_ev = EV_BAD;

    room  = TMAX - now_upd;
    sched = (CW'(period_r) > CW'(room)) ? TMAX : now_upd + TW'(period_r);

    cnt = (order_count_r > CNT_MAX) ? CNT_MAX : order_count_r;
    // right after a request ends, next_poll is now + period (saturated):
    // still closed unless the period is zero or the clock has saturated
    if (end_req)
      poll_open = (period_r == '0) || (now_upd == TMAX);
    else
      poll_open = is_tick && !awaiting_r && !(now_upd < next_poll_r);
    poll_go = poll_open && (cnt != '0);

    idx     = ({1'b0, oidx_r} < cnt) ? oidx_r : '0;
    idx_nxt = (({1'b0, idx} + 5'd1) >= cnt) ? '0 : idx + ID_W'(1);
    pb      = ID_W'(order_table_r >> {idx, 2'b00});
    age_hb  = now_upd - heard_tick_r[pb];
    link_up = heard_r[pb] && (CW'(age_hb) < CW'(direct_to_r));
    skip    = poll_go && en_direct_r && link_up;
    send    = poll_go && !skip && en_acoustic_r;
    pres    = skip || send;

    r0 = '0;
    r1 = '0;
    if (end_req) begin
      r0.ev     = end_ev;
      r0.beacon = pending_r;
      r0.last   = !pres;
      r1.ev     = skip ? EV_SKIP : EV_POLL;
      r1.beacon = pb;
      r1.last   = 1'b1;
      n_res     = pres ? 2'd2 : 2'd1;
    end else begin
      r0.ev     = skip ? EV_SKIP : EV_POLL;
      r0.beacon = pb;
      r0.last   = 1'b1;
      n_res     = pres ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      req_tick_r  <= '0;
      next_poll_r <= '0;
      awaiting_r  <= 1'b0;
      pending_r   <= '0;
      oidx_r      <= '0;
      heard_r     <= '0;
    end else if (accept) begin
      now_r <= now_upd;
      if (send)
        awaiting_r <= 1'b1;
      else if (end_req)
        awaiting_r <= 1'b0;
      if (send) begin
        pending_r  <= pb;
        req_tick_r <= now_upd;
      end
      if (end_req || (poll_go && !send))
        next_poll_r <= sched;
      if (poll_go)
        oidx_r <= idx_nxt;
      if (in_ch.cmd == CMD_HB)
        heard_r[in_ch.beacon] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.cmd == CMD_HB)
      heard_tick_r[in_ch.beacon] <= now_r;
  end

  // ---------------------------------------------------------------------
  // result queue
  logic pop;
  logic [1:0] push_n;

  assign in_ch.ready = (q_cnt_r <= (QP+1)'(QD - 2));
  assign pop         = out_ch.valid && out_ch.ready;
  assign push_n      = accept ? n_res : 2'd0;
  assign q_cnt_nxt   = q_cnt_r + (QP+1)'(push_n) - (QP+1)'(pop);

  assign out_ch.valid        = (q_cnt_r != '0);
  assign out_ch.event_res    = q_r[rd_ptr_r].ev;
  assign out_ch.event_beacon = q_r[rd_ptr_r].beacon;
  assign out_ch.last         = q_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QP'(push_n);
      if (pop)
        rd_ptr_r <= rd_ptr_r + QP'(1);
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0)
      q_r[wr_ptr_r] <= r0;
    if (push_n == 2'd2)
      q_r[wr_ptr_r + QP'(1)] <= r1;
  end

  // ---------------------------------------------------------------------
  logic hb_acc;

  assign hb_acc = accept && (in_ch.cmd == CMD_HB);

  `ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, q_cnt_r <= (QP+1)'(QD))
  `ASSERT_NXT(a_hb_sets_flag, clk, rst_n, hb_acc, heard_r[$past(in_ch.beacon)])
  `ASSERT_NXT(a_hb_keeps_req, clk, rst_n, hb_acc && awaiting_r, awaiting_r && $stable(pending_r))
  `ASSERT_NXT(a_clock_mono, clk, rst_n, accept, now_r >= $past(now_r))

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rrps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [47:0] CLK_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    cmd_t       cmd;
    logic [3:0] beacon;
    logic       for_us;
    logic       decode_ok;
    logic [7:0] status_code;
  } event_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  rrps_in_if  in_ch ();
  rrps_out_if out_ch ();

  round_robin_poll_scheduler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // poller image: configuration
  logic [63:0] tbl;
  logic [4:0]  cnt_reg;
  logic [31:0] period;
  logic [31:0] resp_to;
  logic [31:0] direct_to;
  logic        en_direct;
  logic        en_acoustic;
  logic [7:0]  rto_code;

  // poller image: state
  logic [47:0] now_t;
  logic        busy;
  logic [3:0]  pend;
  logic [47:0] req_t;
  logic [47:0] next_t;
  logic [4:0]  idx_r;
  logic        heard [16];
  logic [47:0] heard_at [16];

  res_t step_out [2];
  int   step_n;
  res_t events_due [$];

  int mismatches = 0;
  int cycle_count = 0;
  int drain_hold = 0;
  bit feed_steady = 1'b0;
  bit drain_steady = 1'b0;

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic [63:0] reg_mask(reg_idx_t r);
    case (r)
      REG_ORDER_TABLE: return '1;
      REG_ORDER_COUNT: return 64'h1F;
      REG_EN_DIRECT, REG_EN_ACOUSTIC: return 64'h1;
      REG_RTO_CODE:    return 64'hFF;
      default:         return 64'hFFFF_FFFF;
    endcase
  endfunction

  task automatic reset_poller();
    tbl = '0;
    cnt_reg = '0;
    period = 32'd100;
    resp_to = 32'd100;
    direct_to = 32'd100;
    en_direct = 1'b0;
    en_acoustic = 1'b1;
    rto_code = '0;
    now_t = '0;
    busy = 1'b0;
    pend = '0;
    req_t = '0;
    next_t = '0;
    idx_r = '0;
    for (int k = 0; k < 16; k++) begin
      heard[k] = 1'b0;
      heard_at[k] = '0;
    end
  endtask

  task automatic note_event(ev_t ev, logic [3:0] b);
    if (step_n < 2) begin
      step_out[step_n].ev = ev;
      step_out[step_n].beacon = b;
      step_out[step_n].last = 1'b0;
      step_n++;
    end
  endtask

  task automatic set_next_poll();
    logic [47:0] room;
    room = CLK_MAX - now_t;
    if ({16'd0, period} > room) next_t = CLK_MAX;
    else next_t = now_t + {16'd0, period};
  endtask

  task automatic try_poll();
    logic [4:0] n;
    logic [4:0] i;
    logic [4:0] nxt;
    logic [3:0] b;
    logic       up;
    n = (cnt_reg > 5'd16) ? 5'd16 : cnt_reg;
    if (busy || n == 5'd0 || now_t < next_t) return;
    // an index left over from a longer list restarts at the head
    i = (idx_r < n) ? idx_r : 5'd0;
    b = tbl[{i[3:0], 2'b00} +: 4];
    nxt = i + 5'd1;
    idx_r = (nxt >= n) ? 5'd0 : nxt;
    up = heard[b] && ((now_t - heard_at[b]) < {16'd0, direct_to});
    if (en_direct && up) begin
      set_next_poll();
      note_event(EV_SKIP, b);
    end else if (en_acoustic) begin
      note_event(EV_POLL, b);
      busy = 1'b1;
      pend = b;
      req_t = now_t;
    end else begin
      set_next_poll();
    end
  endtask

  task automatic end_request(ev_t ev);
    note_event(ev, pend);
    busy = 1'b0;
    set_next_poll();
    try_poll();
  endtask

  task automatic advance_poller(event_word_t w);
    res_t r;
    step_n = 0;
    case (w.cmd)
      CMD_TICK: begin
        if (now_t != CLK_MAX) now_t = now_t + 48'd1;
        if (busy && (now_t - req_t) > {16'd0, resp_to}) end_request(EV_NODE_TO);
        else try_poll();
      end
      CMD_RX: begin
        if (busy && w.for_us && w.beacon == pend) begin
          if (w.decode_ok) end_request(EV_ACCEPT);
          else end_request(EV_BAD);
        end
      end
      CMD_DRV: begin
        if (busy && w.beacon == pend && w.status_code == rto_code) end_request(EV_DRV_TO);
      end
      default: begin
        heard[w.beacon] = 1'b1;
        heard_at[w.beacon] = now_t;
      end
    endcase
    for (int k = 0; k < step_n; k++) begin
      r = step_out[k];
      r.last = (k == step_n - 1);
      events_due = {events_due, r};
    end
  endtask

  // input acceptance is predicted before the result check of the same edge
  always @(posedge clk) begin : scoreboard
    event_word_t w;
    res_t        got;
    res_t        want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w.cmd = cmd_t'(in_ch.cmd);
        w.beacon = in_ch.beacon;
        w.for_us = in_ch.for_us;
        w.decode_ok = in_ch.decode_ok;
        w.status_code = in_ch.status_code;
        advance_poller(w);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.ev = out_ch.event_res;
        got.beacon = out_ch.event_beacon;
        got.last = out_ch.last;
        if (events_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result ev=%0d beacon=%0d last=%0d",
                                 got.ev, got.beacon, got.last));
        end else begin
          want = events_due.pop_front();
          if (got !== want)
            log_mismatch($sformatf({"expected ev=%0d beacon=%0d last=%0d, ",
                                    "got ev=%0d beacon=%0d last=%0d"},
                                   want.ev, want.beacon, want.last,
                                   got.ev, got.beacon, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int gap_len();
    if (feed_steady || $urandom_range(0, 99) < 60) return 0;
    return stall_len();
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (drain_hold > 0) begin
      out_ch.ready <= 1'b0;
      drain_hold--;
    end else if (drain_steady || $urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      drain_hold = stall_len() - 1;
    end
  end

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_word(event_word_t w, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= w.cmd;
    in_ch.beacon <= w.beacon;
    in_ch.for_us <= w.for_us;
    in_ch.decode_ok <= w.decode_ok;
    in_ch.status_code <= w.status_code;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (events_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v = v & reg_mask(r);
    case (r)
      REG_ORDER_TABLE: tbl = v;
      REG_ORDER_COUNT: cnt_reg = v[4:0];
      REG_POLL_PERIOD: period = v[31:0];
      REG_RESP_TO:     resp_to = v[31:0];
      REG_DIRECT_TO:   direct_to = v[31:0];
      REG_EN_DIRECT:   en_direct = v[0];
      REG_EN_ACOUSTIC: en_acoustic = v[0];
      default:         rto_code = v[7:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(reg_idx_t r, logic [63:0] v);
    logic [63:0] got;
    cfg_write(r, v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== (v & reg_mask(r)))
      log_mismatch($sformatf("register %s read %h, expected %h",
                             r.name(), got, v & reg_mask(r)));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setup(logic [63:0] t, logic [4:0] n, logic [31:0] per,
                            logic [31:0] rto, logic [31:0] dto, logic ed, logic ea,
                            logic [7:0] code);
    cfg_write(REG_ORDER_TABLE, t);
    cfg_write(REG_ORDER_COUNT, {59'd0, n});
    cfg_write(REG_POLL_PERIOD, {32'd0, per});
    cfg_write(REG_RESP_TO, {32'd0, rto});
    cfg_write(REG_DIRECT_TO, {32'd0, dto});
    cfg_write(REG_EN_DIRECT, {63'd0, ed});
    cfg_write(REG_EN_ACOUSTIC, {63'd0, ea});
    cfg_write(REG_RTO_CODE, {56'd0, code});
  endtask

  function automatic event_word_t mk(cmd_t c, logic [3:0] b, logic l, logic d, logic [7:0] s);
    event_word_t w;
    w.cmd = c;
    w.beacon = b;
    w.for_us = l;
    w.decode_ok = d;
    w.status_code = s;
    return w;
  endfunction

  // mostly ticks, replies and driver timeouts for the outstanding poll and heartbeats, rest noise
  function automatic event_word_t pick_word();
    event_word_t w;
    int          r;
    logic [3:0]  sel;
    w = mk(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    sel = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      w.cmd = CMD_TICK;
    end else if (r < 65 && busy) begin
      w = mk(CMD_RX, pend, 1'b1, ($urandom_range(0, 3) != 0), w.status_code);
    end else if (r < 73 && busy) begin
      w = mk(CMD_DRV, pend, w.for_us, w.decode_ok, rto_code);
    end else if (r < 85) begin
      w.cmd = CMD_HB;
      w.beacon = tbl[{sel, 2'b00} +: 4];
    end
    return w;
  endfunction

  function automatic logic [31:0] pick_span(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 18) return 32'hFFFF_FFFF;
    return $urandom_range(0, hi);
  endfunction

  task automatic test_idle_after_reset();
    // empty list: nothing may come out whatever arrives
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd15, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_DRV, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_HB, 4'd15, 1'b1, 1'b1, 8'hFF), gap_len());
    wait_idle();
  endtask

  task automatic test_registers();
    for (int k = 0; k < 8; k++) begin
      cfg_check(reg_idx_t'(k), '1);
      cfg_check(reg_idx_t'(k), 64'hA5A5_5A5A_0F0F_F0F0);
      cfg_check(reg_idx_t'(k), '0);
    end
  endtask

  task automatic test_poll_cycle();
    // list 0, 15, 5
    load_setup(64'h5F0, 5'd3, 32'd0, 32'd2, 32'd4, 1'b0, 1'b1, 8'hFF);
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd0, 1'b0, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd15, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd0, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd15, 1'b1, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_DRV, 4'd5, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_DRV, 4'd5, 1'b0, 1'b0, 8'hFF), gap_len());
    // no reply: the node gives up after the response timeout
    repeat (3) send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    wait_idle();
  endtask

  task automatic test_direct_skip();
    cfg_write(REG_EN_DIRECT, 64'd1);
    send_word(mk(CMD_HB, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd15, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_RX, 4'd5, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    wait_idle();
  endtask

  task automatic test_acoustic_off();
    cfg_write(REG_EN_ACOUSTIC, 64'd0);
    send_word(mk(CMD_RX, 4'd15, 1'b1, 1'b1, 8'd0), gap_len());
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    wait_idle();
    // shrink the list below the current index
    cfg_write(REG_ORDER_COUNT, 64'd1);
    cfg_write(REG_EN_ACOUSTIC, 64'd1);
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    send_word(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 8'd0), gap_len());
    wait_idle();
  endtask

  task automatic run_phase(int p, int n_words, bit last_phase);
    logic [63:0] t;
    logic [4:0]  n;
    if (p == 0) begin
      load_setup(64'hFEDC_BA98_7654_3210, 5'd16, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 8'd0);
    end else if (last_phase) begin
      load_setup('1, 5'd31, '1, '1, '1, 1'b1, 1'b1, 8'hFF);
    end else begin
      t = {$urandom, $urandom};
      n = (p == 2) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 16));
      // a huge period would stall polling for the rest of the run
      load_setup(t, n, $urandom_range(0, 6), pick_span(8), pick_span(20),
                 1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0),
                 8'($urandom_range(0, 255)));
    end
    feed_steady = (p == 3 || p == 5);
    drain_steady = (p == 4 || p == 5);
    for (int i = 0; i < n_words; i++) begin
      if (i == n_words / 2) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (events_due.size() != 0);
      end
      send_word(pick_word(), gap_len());
    end
    feed_steady = 1'b0;
    drain_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int phase_len [8];
    phase_len = '{200, 250, 250, 200, 250, 200, 250, 100};
    for (int p = 0; p < 8; p++) run_phase(p, phase_len[p], p == 7);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.beacon = '0;
    in_ch.for_us = 1'b0;
    in_ch.decode_ok = 1'b0;
    in_ch.status_code = '0;
    out_ch.ready = 1'b0;
    reset_poller();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_after_reset();
    test_registers();
    test_poll_cycle();
    test_direct_skip();
    test_acoustic_off();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
